FILE: sv/cuyr_pkg.sv
// cuyr_pkg: shared types, codes, constants and arithmetic helpers for chroma upsampling and color conversion
`default_nettype none

package cuyr_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_INTERIOR = 2'd1;
    localparam logic [1:0] OP_CLOSE    = 2'd2;

    // bt.601 14-bit fixed-point coefficients
    localparam logic [15:0] COEF_Y  = 16'd19077;
    localparam logic [15:0] COEF_VR = 16'd26149;
    localparam logic [15:0] COEF_UG = 16'd6419;
    localparam logic [15:0] COEF_VG = 16'd13320;
    localparam logic [15:0] COEF_UB = 16'd33050;

    localparam logic signed [17:0] OFS_R = 18'sd14234;
    localparam logic signed [17:0] OFS_G = 18'sd8708;
    localparam logic signed [17:0] OFS_B = 18'sd17685;

    localparam int FRAC_BITS = 6;
    localparam logic signed [17:0] CLIP_MAX = 18'sd16383;

    // one pixel on its way to color conversion
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        logic       row;
        logic       last;
    } pix_t;

    // (3*near + far + 2) >> 2
    function automatic logic [7:0] blend31(input logic [7:0] near, input logic [7:0] far);
        logic [9:0] s;
        s = {1'b0, near, 1'b0} + {2'b00, near} + {2'b00, far} + 10'd2;
        return s[9:2];
    endfunction

    // diagonal 9:3:3:1 chroma for the four pixels of an interior column
    // packed as {top first, top second, bottom first, bottom second}
    function automatic logic [31:0] fancy4(input logic [7:0] pu, input logic [7:0] cu,
                                           input logic [7:0] pl, input logic [7:0] cb);
        logic [10:0] avg;
        logic [8:0]  s12;
        logic [8:0]  s03;
        logic [11:0] t12;
        logic [11:0] t03;
        logic [8:0]  d12;
        logic [8:0]  d03;
        logic [9:0]  c0;
        logic [9:0]  c1;
        logic [9:0]  c2;
        logic [9:0]  c3;
        avg = {3'b000, pu} + {3'b000, cu} + {3'b000, pl} + {3'b000, cb} + 11'd8;
        s12 = {1'b0, cu} + {1'b0, pl};
        s03 = {1'b0, pu} + {1'b0, cb};
        t12 = {1'b0, avg} + {2'b00, s12, 1'b0};
        t03 = {1'b0, avg} + {2'b00, s03, 1'b0};
        d12 = t12[11:3];
        d03 = t03[11:3];
        c0  = {1'b0, d12} + {2'b00, pu};
        c1  = {1'b0, d03} + {2'b00, cu};
        c2  = {1'b0, d03} + {2'b00, pl};
        c3  = {1'b0, d12} + {2'b00, cb};
        return {c0[8:1], c1[8:1], c2[8:1], c3[8:1]};
    endfunction

    // (v * coeff) >> 8
    function automatic logic [15:0] scale_hi(input logic [7:0] v, input logic [15:0] coeff);
        logic [23:0] p;
        p = {16'd0, v} * {8'd0, coeff};
        return p[23:8];
    endfunction

    // clamp to 0..255 after dropping the fraction bits
    function automatic logic [7:0] sat8(input logic signed [17:0] x);
        logic [7:0] r;
        if (x < 18'sd0)
        begin
            r = 8'd0;
        end
        else if (x > CLIP_MAX)
        begin
            r = 8'd255;
        end
        else
        begin
            r = x[FRAC_BITS +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cuyr_upsample.sv
// cuyr_upsample: chroma history, per-pixel chroma build and pixel sequencing of one column
`default_nettype none

module cuyr_upsample
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     operation,
    input  wire logic           has_bottom,
    input  wire logic [7:0]     upper_chroma_u,
    input  wire logic [7:0]     upper_chroma_v,
    input  wire logic [7:0]     lower_chroma_u,
    input  wire logic [7:0]     lower_chroma_v,
    input  wire logic [7:0]     top_luma_first,
    input  wire logic [7:0]     top_luma_second,
    input  wire logic [7:0]     bottom_luma_first,
    input  wire logic [7:0]     bottom_luma_second,
    output logic                pix_valid,
    output cuyr_pkg::pix_t      pix,
    input  wire logic           pix_ready
);
    import cuyr_pkg::*;

    // chroma of the previous column
    logic [7:0] prev_uu_reg;
    logic [7:0] prev_uv_reg;
    logic [7:0] prev_lu_reg;
    logic [7:0] prev_lv_reg;

    // pixel buffer of the current column
    pix_t       buf_reg [4];
    pix_t       buf_next [4];
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [1:0] last_idx_reg;
    logic [1:0] last_idx_next;
    logic       busy_reg;
    logic       busy_next;

    logic       accept;
    logic       pix_fire;
    logic       done;
    logic       loads;
    logic [7:0] su_u;
    logic [7:0] su_v;
    logic [7:0] sl_u;
    logic [7:0] sl_v;
    logic [31:0] fu;
    logic [31:0] fv;

    // handshake
    assign pix_valid = busy_reg;
    assign pix_fire  = busy_reg & pix_ready;
    assign done      = pix_fire & (idx_reg == last_idx_reg);
    assign in_ready  = ~busy_reg | done;
    assign accept    = in_valid & in_ready;
    assign loads     = accept & ((operation == OP_START) | (operation == OP_INTERIOR) |
                                 (operation == OP_CLOSE));

    // current pixel out of the buffer
    always_comb
    begin
        pix      = buf_reg[idx_reg];
        pix.last = (idx_reg == last_idx_reg);
    end

    // chroma source for the 3:1 blend: new column at line start, history otherwise
    assign su_u = (operation == OP_START) ? upper_chroma_u : prev_uu_reg;
    assign su_v = (operation == OP_START) ? upper_chroma_v : prev_uv_reg;
    assign sl_u = (operation == OP_START) ? lower_chroma_u : prev_lu_reg;
    assign sl_v = (operation == OP_START) ? lower_chroma_v : prev_lv_reg;

    assign fu = fancy4(prev_uu_reg, upper_chroma_u, prev_lu_reg, lower_chroma_u);
    assign fv = fancy4(prev_uv_reg, upper_chroma_v, prev_lv_reg, lower_chroma_v);

    // next pixel list for an accepted word
    always_comb
    begin
        buf_next      = buf_reg;
        last_idx_next = last_idx_reg;
        case (operation)
            OP_INTERIOR:
            begin
                buf_next[0]   = '{y: top_luma_first, u: fu[31:24], v: fv[31:24],
                                  row: 1'b0, last: 1'b0};
                buf_next[1]   = '{y: top_luma_second, u: fu[23:16], v: fv[23:16],
                                  row: 1'b0, last: 1'b0};
                buf_next[2]   = '{y: bottom_luma_first, u: fu[15:8], v: fv[15:8],
                                  row: 1'b1, last: 1'b0};
                buf_next[3]   = '{y: bottom_luma_second, u: fu[7:0], v: fv[7:0],
                                  row: 1'b1, last: 1'b0};
                last_idx_next = has_bottom ? 2'd3 : 2'd1;
            end
            OP_START, OP_CLOSE:
            begin
                buf_next[0]   = '{y: top_luma_first, u: blend31(su_u, sl_u),
                                  v: blend31(su_v, sl_v), row: 1'b0, last: 1'b0};
                buf_next[1]   = '{y: bottom_luma_first, u: blend31(sl_u, su_u),
                                  v: blend31(sl_v, su_v), row: 1'b1, last: 1'b0};
                last_idx_next = has_bottom ? 2'd1 : 2'd0;
            end
            default:
            begin
                buf_next      = buf_reg;
                last_idx_next = last_idx_reg;
            end
        endcase
    end

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (accept)
        begin
            busy_next = loads;
            idx_next  = 2'd0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            idx_next  = 2'd0;
        end
        else if (pix_fire)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            idx_reg     <= 2'd0;
            prev_uu_reg <= 8'd0;
            prev_uv_reg <= 8'd0;
            prev_lu_reg <= 8'd0;
            prev_lv_reg <= 8'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            // history follows line start and interior columns
            if (accept & ((operation == OP_START) | (operation == OP_INTERIOR)))
            begin
                prev_uu_reg <= upper_chroma_u;
                prev_uv_reg <= upper_chroma_v;
                prev_lu_reg <= lower_chroma_u;
                prev_lv_reg <= lower_chroma_v;
            end
        end
    end

    // pixel payload
    always_ff @(posedge clk)
    begin
        if (loads)
        begin
            buf_reg      <= buf_next;
            last_idx_reg <= last_idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cuyr_convert.sv
// cuyr_convert: yuv to rgb conversion into the result register
`default_nettype none

module cuyr_convert
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pix_valid,
    input  wire cuyr_pkg::pix_t pix,
    output logic                pix_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic                row_select,
    output logic                last_of_item
);
    import cuyr_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic             row_reg;
    logic             last_reg;
    logic             load;
    logic [15:0]      yy;
    logic [15:0]      vr;
    logic [15:0]      ug;
    logic [15:0]      vg;
    logic [15:0]      ub;
    logic signed [17:0] r_sum;
    logic signed [17:0] g_sum;
    logic signed [17:0] b_sum;

    assign pix_ready = ~valid_reg | out_ready;
    assign load      = pix_valid & pix_ready;

    // scaled luma and chroma terms
    assign yy = scale_hi(pix.y, COEF_Y);
    assign vr = scale_hi(pix.v, COEF_VR);
    assign ug = scale_hi(pix.u, COEF_UG);
    assign vg = scale_hi(pix.v, COEF_VG);
    assign ub = scale_hi(pix.u, COEF_UB);

    // channel sums before clamping
    assign r_sum = $signed({2'b00, yy}) + $signed({2'b00, vr}) - OFS_R;
    assign g_sum = $signed({2'b00, yy}) - $signed({2'b00, ug}) - $signed({2'b00, vg}) + OFS_G;
    assign b_sum = $signed({2'b00, yy}) + $signed({2'b00, ub}) - OFS_B;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= sat8(r_sum);
            green_reg <= sat8(g_sum);
            blue_reg  <= sat8(b_sum);
            row_reg   <= pix.row;
            last_reg  <= pix.last;
        end
    end

    assign out_valid    = valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign row_select   = row_reg;
    assign last_of_item = last_reg;

endmodule

`default_nettype wire

FILE: sv/chroma_upsample_yuv_to_rgb_core.sv
// chroma_upsample_yuv_to_rgb_core: 4:2:0 fancy upsampling and bt.601 yuv to rgb, top level
//
//  channel   handshake              word
//  input     in_valid / in_ready    operation, has_bottom, chroma of column, four luma
//  output    out_valid / out_ready  red, green, blue, row_select, last_of_item
//
//  an input word yields 1, 2 or 4 pixels (none for the unused code), one per cycle from
//  the column buffer unless a stall on out_ready holds them back.
//  a new word is taken in the cycle the last pixel of the previous one moves on.
//  conversion sits combinationally between the column buffer and the result register.
//  reset clears the chroma history and all valid flags; stalls on out_ready hold the
//  result register and back up into the column buffer.
`default_nettype none

module chroma_upsample_yuv_to_rgb_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] operation,
    input  wire logic       has_bottom,
    input  wire logic [7:0] upper_chroma_u,
    input  wire logic [7:0] upper_chroma_v,
    input  wire logic [7:0] lower_chroma_u,
    input  wire logic [7:0] lower_chroma_v,
    input  wire logic [7:0] top_luma_first,
    input  wire logic [7:0] top_luma_second,
    input  wire logic [7:0] bottom_luma_first,
    input  wire logic [7:0] bottom_luma_second,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic            row_select,
    output logic            last_of_item
);
    import cuyr_pkg::*;

    logic pix_valid;
    logic pix_ready;
    pix_t pix;

    // chroma upsampling and pixel sequencing
    cuyr_upsample u_upsample
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .operation          (operation),
        .has_bottom         (has_bottom),
        .upper_chroma_u     (upper_chroma_u),
        .upper_chroma_v     (upper_chroma_v),
        .lower_chroma_u     (lower_chroma_u),
        .lower_chroma_v     (lower_chroma_v),
        .top_luma_first     (top_luma_first),
        .top_luma_second    (top_luma_second),
        .bottom_luma_first  (bottom_luma_first),
        .bottom_luma_second (bottom_luma_second),
        .pix_valid          (pix_valid),
        .pix                (pix),
        .pix_ready          (pix_ready)
    );

    // color conversion and result register
    cuyr_convert u_convert
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix          (pix),
        .pix_ready    (pix_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .row_select   (row_select),
        .last_of_item (last_of_item)
    );

endmodule

`default_nettype wire
